// ===== rtl/bdpb_pkg.sv =====
// shared types, constants and helpers for the brush dab pixel blend
`timescale 1ns / 1ps
`default_nettype none

package bdpb_pkg;

  localparam int CANVAS_SIZE = 4096;
  localparam int D2_W        = 24;          // squared distance inside the dab
  localparam int RAD_W       = D2_W + 16;   // radicand d2 << 16
  localparam int DD_W        = RAD_W / 2;   // floor(256 * dist)
  localparam int SQ_STEPS    = DD_W;        // one root bit per stage
  localparam int SQ_REM_W    = DD_W + 3;
  localparam int Q_STEPS     = 8;           // 8-bit quotients

  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_DAB_RADIUS = 3'd2,
    REG_HARDNESS   = 3'd3,
    REG_OPACITY    = 3'd4,
    REG_COLOR      = 3'd5,
    REG_ERASE      = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [11:0] radius;
    logic [7:0]  hardness;
    logic [7:0]  opacity;
    logic [23:0] color;
    logic        erase;
  } cfg_t;

  // values derived from the dab registers, refreshed every cycle
  typedef struct packed {
    logic [23:0] rr;     // r * r
    logic [19:0] hr;     // hardness * r
    logic [39:0] hhrr;   // (hardness * r)^2
    logic [19:0] den;    // r * (255 - hardness)
  } cdrv_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

  typedef struct packed {
    pix_t pix;
    logic in_dab;
    logic full;
  } meta_t;

  typedef struct packed {
    meta_t           meta;
    logic [D2_W-1:0] d2;
  } geo_t;

  // underestimate of x / 255, off by at most one
  function automatic logic [8:0] div255_est(input logic [15:0] x);
    logic [24:0] p;
    p = {9'd0, x} * 25'd257;
    return p[24:16];
  endfunction

  // corrects the estimate to floor(x / 255)
  function automatic logic [8:0] div255_fix(input logic [15:0] x, input logic [8:0] q);
    logic [16:0] prod;
    logic [16:0] rem;
    prod = {8'd0, q} * 17'd255;
    rem  = {1'b0, x} - prod;
    return q + ((rem >= 17'd255) ? 9'd1 : 9'd0);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/brush_dab_pixel_blend.sv =====
// brush dab pixel blend: pipeline from input transaction to result
// throughput one pixel per cycle; the whole 50-stage pipeline moves together
// and holds while a finished result is stalled at the output register
// stages: 5 distance, 20 square root (one root bit each), 13 falloff, 12 blend
// synchronous active-high reset clears valid bits and loads register defaults
`timescale 1ns / 1ps
`default_nettype none

module brush_dab_pixel_blend (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  // pixel input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] pixel_x,
  input  logic [11:0] pixel_y,
  input  logic [7:0]  dst_red,
  input  logic [7:0]  dst_green,
  input  logic [7:0]  dst_blue,
  input  logic [7:0]  dst_alpha,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic        write_pixel
);
  import bdpb_pkg::*;

  cfg_t        cfg;
  cdrv_t       drv;
  logic [11:0] r_eff;
  logic        en;
  pix_t        in_pix;

  logic  geo_valid, sq_valid, fo_valid;
  geo_t  geo;
  meta_t sq_meta, fo_meta;
  logic [DD_W-1:0] dd;
  logic [7:0] fo_alpha;

  // config writes are always taken; write only while the block is idle (the block does not enforce it)
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x <= 16'd0;
      cfg.center_y <= 16'd0;
      cfg.radius   <= 12'd8;
      cfg.hardness <= 8'd255;
      cfg.opacity  <= 8'd255;
      cfg.color    <= 24'd0;
      cfg.erase    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CENTER_X:   cfg.center_x <= cfg_data[15:0];
        REG_CENTER_Y:   cfg.center_y <= cfg_data[15:0];
        REG_DAB_RADIUS: cfg.radius   <= cfg_data[11:0];
        REG_HARDNESS:   cfg.hardness <= cfg_data[7:0];
        REG_OPACITY:    cfg.opacity  <= cfg_data[7:0];
        REG_COLOR:      cfg.color    <= cfg_data;
        REG_ERASE:      cfg.erase    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // tiny radii act as half a pixel
  assign r_eff = (cfg.radius < 12'd2) ? 12'd8 : cfg.radius;

  // derived dab terms, registered; hhrr is registered from the registered hr, so it settles last
  always_ff @(posedge clk) begin
    drv.rr   <= {12'd0, r_eff} * {12'd0, r_eff};
    drv.hr   <= {12'd0, cfg.hardness} * {8'd0, r_eff};
    drv.den  <= {12'd0, 8'd255 - cfg.hardness} * {8'd0, r_eff};
    drv.hhrr <= {20'd0, drv.hr} * {20'd0, drv.hr};
  end

  // one enable for the whole pipeline: only a stalled result holds it
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign in_pix.red   = dst_red;
  assign in_pix.green = dst_green;
  assign in_pix.blue  = dst_blue;
  assign in_pix.alpha = dst_alpha;

  bdpb_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .in_pix    (in_pix),
    .cfg       (cfg),
    .drv       (drv),
    .out_valid (geo_valid),
    .out_geo   (geo)
  );

  bdpb_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (geo_valid),
    .in_geo    (geo),
    .out_valid (sq_valid),
    .out_meta  (sq_meta),
    .dd        (dd)
  );

  bdpb_falloff u_falloff (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .in_meta   (sq_meta),
    .dd        (dd),
    .cfg       (cfg),
    .drv       (drv),
    .out_valid (fo_valid),
    .out_meta  (fo_meta),
    .alpha     (fo_alpha)
  );

  bdpb_blend u_blend (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (fo_valid),
    .in_meta     (fo_meta),
    .alpha       (fo_alpha),
    .cfg         (cfg),
    .out_valid   (out_valid),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_alpha   (out_alpha),
    .write_pixel (write_pixel)
  );

  // a result left waiting must still be there in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(write_pixel) && $stable(out_alpha))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== rtl/bdpb_geom.sv =====
// distance, inside test and full-alpha test, five stages
`timescale 1ns / 1ps
`default_nettype none

module bdpb_geom (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [11:0]      pixel_x,
  input  logic [11:0]      pixel_y,
  input  bdpb_pkg::pix_t   in_pix,
  input  bdpb_pkg::cfg_t   cfg,
  input  bdpb_pkg::cdrv_t  drv,
  output logic             out_valid,
  output bdpb_pkg::geo_t   out_geo
);
  import bdpb_pkg::*;

  logic [15:0] pos_x, pos_y, dx, dy;
  logic        oob;
  logic [32:0] sum;

  logic v0, v1, v2, v3;
  pix_t pix0, pix1, pix2, pix3;
  logic [15:0] dx0, dy0;
  logic oob0, oob1;
  logic [31:0] sqx1, sqy1;
  logic in2, in3;
  logic [D2_W-1:0] d2_2, d2_3;
  logic [39:0] lhs3;

  always_comb begin
    pos_x = {pixel_x, 4'd8};
    pos_y = {pixel_y, 4'd8};
    dx    = (pos_x >= cfg.center_x) ? pos_x - cfg.center_x : cfg.center_x - pos_x;
    dy    = (pos_y >= cfg.center_y) ? pos_y - cfg.center_y : cfg.center_y - pos_y;
    oob   = (17'(pixel_x) >= 17'(CANVAS_SIZE)) || (17'(pixel_y) >= 17'(CANVAS_SIZE));
    sum   = 33'(sqx1) + 33'(sqy1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix0 <= in_pix;
      dx0  <= dx;
      dy0  <= dy;
      oob0 <= oob;

      pix1 <= pix0;
      sqx1 <= {16'd0, dx0} * {16'd0, dx0};
      sqy1 <= {16'd0, dy0} * {16'd0, dy0};
      oob1 <= oob0;

      pix2 <= pix1;
      in2  <= !oob1 && (sum <= {9'd0, drv.rr});
      d2_2 <= sum[D2_W-1:0];

      pix3 <= pix2;
      in3  <= in2;
      d2_3 <= d2_2;
      lhs3 <= {16'd0, d2_2} * 40'd65025;

      out_geo.meta.pix    <= pix3;
      out_geo.meta.in_dab <= in3;
      out_geo.meta.full   <= lhs3 <= drv.hhrr;
      out_geo.d2          <= d2_3;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_geo.meta.in_dab |-> {16'd0, out_geo.d2} <= {16'd0, drv.rr})
    else $error("inside flag set beyond the radius");

endmodule

`default_nettype wire

// ===== rtl/bdpb_sqrt.sv =====
// pipelined integer square root of d2 << 16, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none

module bdpb_sqrt (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  bdpb_pkg::geo_t        in_geo,
  output logic                  out_valid,
  output bdpb_pkg::meta_t       out_meta,
  output logic [bdpb_pkg::DD_W-1:0] dd
);
  import bdpb_pkg::*;

  logic [SQ_STEPS-1:0] v_q;
  meta_t               meta_q [SQ_STEPS];
  logic [RAD_W-1:0]    rad_q  [SQ_STEPS];
  logic [SQ_REM_W-1:0] rem_q  [SQ_STEPS];
  logic [DD_W-1:0]     root_q [SQ_STEPS];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
    logic                v_in;
    meta_t               m_in;
    logic [RAD_W-1:0]    rad_in;
    logic [SQ_REM_W-1:0] rem_in, rem_sh, trial;
    logic [DD_W-1:0]     root_in;

    if (i == 0) begin : g_first
      assign v_in    = in_valid;
      assign m_in    = in_geo.meta;
      assign rad_in  = {in_geo.d2, 16'd0};
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign v_in    = v_q[i-1];
      assign m_in    = meta_q[i-1];
      assign rad_in  = rad_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    always_comb begin
      rem_sh = {rem_in[SQ_REM_W-3:0], rad_in[RAD_W-1 -: 2]};
      trial  = {1'b0, root_in, 2'b01};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (en) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        meta_q[i] <= m_in;
        rad_q[i]  <= {rad_in[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_q[i]  <= rem_sh - trial;
          root_q[i] <= {root_in[DD_W-2:0], 1'b1};
        end else begin
          rem_q[i]  <= rem_sh;
          root_q[i] <= {root_in[DD_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v_q[SQ_STEPS-1];
  assign out_meta  = meta_q[SQ_STEPS-1];
  assign dd        = root_q[SQ_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/bdpb_falloff.sv =====
// linear falloff past the hardness radius and opacity scaling
`timescale 1ns / 1ps
`default_nettype none

module bdpb_falloff (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  bdpb_pkg::meta_t           in_meta,
  input  logic [bdpb_pkg::DD_W-1:0] dd,
  input  bdpb_pkg::cfg_t            cfg,
  input  bdpb_pkg::cdrv_t           drv,
  output logic                      out_valid,
  output bdpb_pkg::meta_t           out_meta,
  output logic [7:0]                alpha
);
  import bdpb_pkg::*;

  logic [27:0] t255, hr256, den28;
  logic [7:0]  lin;

  logic        v0, v1, v10, v11;
  meta_t       m0, m1, m10, m11;
  logic [27:0] num0;
  logic [35:0] dvd1;
  logic [15:0] x10, x11;
  logic [8:0]  qe11;

  logic [Q_STEPS-1:0] v_q;
  meta_t              meta_q [Q_STEPS];
  logic [35:0]        rem_q  [Q_STEPS];
  logic [7:0]         quo_q  [Q_STEPS];

  always_comb begin
    t255  = {dd, 8'd0} - {8'd0, dd};
    hr256 = {drv.hr, 8'd0};
    den28 = {drv.den, 8'd0};
    lin   = meta_q[Q_STEPS-1].full ? 8'd255 : 8'd255 - quo_q[Q_STEPS-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v10 <= v_q[Q_STEPS-1];
      v11 <= v10;
      out_valid <= v11;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0   <= in_meta;
      num0 <= (t255 > hr256) ? t255 - hr256 : 28'd0;
      m1   <= m0;
      dvd1 <= {num0, 8'd0} - {8'd0, num0};
      m10  <= meta_q[Q_STEPS-1];
      x10  <= 16'({8'd0, lin} * {8'd0, cfg.opacity}) + 16'd127;
      m11  <= m10;
      x11  <= x10;
      qe11 <= div255_est(x10);
      out_meta <= m11;
      alpha    <= 8'(div255_fix(x11, qe11));
    end
  end

  // restoring divide, quotient below 256 whenever the falloff applies
  for (genvar j = 0; j < Q_STEPS; j++) begin : g_div
    logic        v_in;
    meta_t       m_in;
    logic [35:0] rem_in, den_sh;
    logic [7:0]  quo_in;

    if (j == 0) begin : g_first
      assign v_in   = v1;
      assign m_in   = m1;
      assign rem_in = dvd1;
      assign quo_in = '0;
    end else begin : g_next
      assign v_in   = v_q[j-1];
      assign m_in   = meta_q[j-1];
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    assign den_sh = {8'd0, den28} << (Q_STEPS - 1 - j);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[j] <= 1'b0;
      end else if (en) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        meta_q[j] <= m_in;
        if (rem_in >= den_sh) begin
          rem_q[j] <= rem_in - den_sh;
          quo_q[j] <= {quo_in[6:0], 1'b1};
        end else begin
          rem_q[j] <= rem_in;
          quo_q[j] <= {quo_in[6:0], 1'b0};
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> alpha <= cfg.opacity)
    else $error("dab alpha above opacity");

endmodule

`default_nettype wire

// ===== rtl/bdpb_blend.sv =====
// source-over paint and erase compositing with output register
`timescale 1ns / 1ps
`default_nettype none

module bdpb_blend (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  bdpb_pkg::meta_t in_meta,
  input  logic [7:0]      alpha,
  input  bdpb_pkg::cfg_t  cfg,
  output logic            out_valid,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic [7:0]      out_alpha,
  output logic            write_pixel
);
  import bdpb_pkg::*;

  typedef struct packed {
    meta_t       meta;
    logic [15:0] a2;
    logic [7:0]  a2q;
    logic [7:0]  ea;
    logic [2:0]  sat;
  } side_t;

  logic [7:0]  ia;
  logic [31:0] dvd [3];

  logic        v0, v1, v2;
  meta_t       m0, m1;
  logic [7:0]  a0;
  logic [15:0] pda0, pda1, a2_0, a2_1;
  logic [23:0] num1 [3];
  logic [8:0]  a2e1, pdae1;
  side_t       s2;
  logic [23:0] rem2 [3];

  logic [Q_STEPS-1:0] v_q;
  side_t              side_q [Q_STEPS];
  logic [23:0]        rem_q  [Q_STEPS][3];
  logic [7:0]         quo_q  [Q_STEPS][3];

  side_t fin;
  logic [7:0] chan [3];

  always_comb begin
    ia      = 8'd255 - alpha;
    for (int c = 0; c < 3; c++) begin
      dvd[c] = {num1[c], 8'd0} - {8'd0, num1[c]};
    end
    fin = side_q[Q_STEPS-1];
    for (int c = 0; c < 3; c++) begin
      chan[c] = fin.sat[c] ? 8'd255 : quo_q[Q_STEPS-1][c];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      out_valid <= v_q[Q_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0   <= in_meta;
      a0   <= alpha;
      pda0 <= {8'd0, in_meta.pix.alpha} * {8'd0, ia};
      a2_0 <= ({alpha, 8'd0} - {8'd0, alpha}) + ({8'd0, in_meta.pix.alpha} * {8'd0, ia});

      m1    <= m0;
      pda1  <= pda0;
      a2_1  <= a2_0;
      a2e1  <= div255_est(a2_0);
      pdae1 <= div255_est(pda0);

      s2.meta <= m1;
      s2.a2   <= a2_1;
      s2.a2q  <= 8'(div255_fix(a2_1, a2e1));
      s2.ea   <= 8'(div255_fix(pda1, pdae1));
      for (int c = 0; c < 3; c++) begin
        s2.sat[c] <= dvd[c] >= {8'd0, a2_1, 8'd0};
        rem2[c]   <= dvd[c][23:0];
      end
    end
  end

  // num1 is computed from stage 0 values
  always_ff @(posedge clk) begin
    if (en) begin
      num1[0] <= {16'd0, cfg.color[23:16]} * {16'd0, a0} +
                 {16'd0, m0.pix.red} * {8'd0, pda0};
      num1[1] <= {16'd0, cfg.color[15:8]} * {16'd0, a0} +
                 {16'd0, m0.pix.green} * {8'd0, pda0};
      num1[2] <= {16'd0, cfg.color[7:0]} * {16'd0, a0} +
                 {16'd0, m0.pix.blue} * {8'd0, pda0};
    end
  end

  // per-channel restoring divide by the blended alpha
  for (genvar j = 0; j < Q_STEPS; j++) begin : g_div
    logic        v_in;
    side_t       s_in;
    logic [23:0] rem_in [3];
    logic [7:0]  quo_in [3];
    logic [23:0] den_sh;

    if (j == 0) begin : g_first
      assign v_in = v2;
      assign s_in = s2;
      for (genvar c = 0; c < 3; c++) begin : g_ch
        assign rem_in[c] = rem2[c];
        assign quo_in[c] = '0;
      end
    end else begin : g_next
      assign v_in = v_q[j-1];
      assign s_in = side_q[j-1];
      for (genvar c = 0; c < 3; c++) begin : g_ch
        assign rem_in[c] = rem_q[j-1][c];
        assign quo_in[c] = quo_q[j-1][c];
      end
    end

    assign den_sh = {8'd0, s_in.a2} << (Q_STEPS - 1 - j);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[j] <= 1'b0;
      end else if (en) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[j] <= s_in;
        for (int c = 0; c < 3; c++) begin
          if (rem_in[c] >= den_sh) begin
            rem_q[j][c] <= rem_in[c] - den_sh;
            quo_q[j][c] <= {quo_in[c][6:0], 1'b1};
          end else begin
            rem_q[j][c] <= rem_in[c];
            quo_q[j][c] <= {quo_in[c][6:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_red     <= fin.meta.pix.red;
      out_green   <= fin.meta.pix.green;
      out_blue    <= fin.meta.pix.blue;
      out_alpha   <= fin.meta.pix.alpha;
      write_pixel <= 1'b0;
      if (fin.meta.in_dab) begin
        if (cfg.erase) begin
          out_alpha   <= fin.ea;
          write_pixel <= 1'b1;
        end else if (fin.a2 != 16'd0) begin
          out_red     <= chan[0];
          out_green   <= chan[1];
          out_blue    <= chan[2];
          out_alpha   <= fin.a2q;
          write_pixel <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && write_pixel && !cfg.erase |-> out_alpha != 8'd0)
    else $error("painted pixel written with zero alpha");

endmodule

`default_nettype wire
